### rtl/mihd_pkg.sv
// ----------------------------------------------------------------------------
// Masked iris code Hamming distance: shared package
// Widths, limits, the totals record passed from the accumulator to the
// divider, and the byte population count.
// ----------------------------------------------------------------------------
package mihd_pkg;

    localparam int COUNT_W     = 14;
    localparam int RATIO_W     = 17;
    localparam int BYTE_W      = 8;
    localparam int POP_W       = 4;
    localparam int FRAC_BITS   = 16;

    // Longest template, in byte pairs.
    localparam int MAX_BYTES   = 1024;
    localparam int BIT_LIMIT_RAW = MAX_BYTES * BYTE_W;
    localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
    localparam int BIT_LIMIT   = (BIT_LIMIT_RAW > COUNT_MAX) ? COUNT_MAX : BIT_LIMIT_RAW;

    // Depth of the queue between accumulator and divider.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Quotient bits: the integer bit (ratio of exactly one) plus the fraction.
    localparam int DIV_STEPS   = FRAC_BITS + 1;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic [COUNT_W-1:0] differ;
        logic [COUNT_W-1:0] valid;
    } mihd_totals_t;

    function automatic logic [POP_W-1:0] ones_in_byte(input logic [BYTE_W-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int k = 0; k < BYTE_W; k++)
        begin
            n = n + POP_W'(v[k]);
        end
        return n;
    endfunction

endpackage

### rtl/mihd_front.sv
// ----------------------------------------------------------------------------
// Masked iris code Hamming distance: accumulator
// Takes one byte pair per cycle while the queue is not full, counts jointly
// valid and differing bits, and queues the totals of each finished template.
// ----------------------------------------------------------------------------
module mihd_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [mihd_pkg::BYTE_W-1:0] code_a,
    input  logic [mihd_pkg::BYTE_W-1:0] mask_a,
    input  logic [mihd_pkg::BYTE_W-1:0] code_b,
    input  logic [mihd_pkg::BYTE_W-1:0] mask_b,
    input  logic                        final_byte,
    input  logic                        q_full,
    output logic                        q_push,
    output mihd_pkg::mihd_totals_t      q_data
);
    import mihd_pkg::*;

    logic [COUNT_W-1:0] differ_reg, differ_next;
    logic [COUNT_W-1:0] valid_reg, valid_next;
    logic [BYTE_W-1:0]  joint;
    logic [BYTE_W-1:0]  diff;
    logic [POP_W-1:0]   nv;
    logic [POP_W-1:0]   nd;
    logic [COUNT_W:0]   valid_sum;
    logic               fits;
    logic               accept;
    logic [COUNT_W-1:0] differ_upd;
    logic [COUNT_W-1:0] valid_upd;

    always_comb
    begin
        accept    = push && !q_full;
        joint     = mask_a & mask_b;
        diff      = (code_a ^ code_b) & joint;
        nv        = ones_in_byte(joint);
        nd        = ones_in_byte(diff);
        valid_sum = {1'b0, valid_reg} + (COUNT_W + 1)'(nv);
        // A byte pair that would take the valid count past the limit is dropped whole.
        fits      = valid_sum <= (COUNT_W + 1)'(BIT_LIMIT);

        valid_upd  = fits ? valid_sum[COUNT_W-1:0] : valid_reg;
        differ_upd = fits ? differ_reg + COUNT_W'(nd) : differ_reg;

        q_push        = accept && final_byte;
        q_data.differ = differ_upd;
        q_data.valid  = valid_upd;

        differ_next = differ_reg;
        valid_next  = valid_reg;
        if (accept)
        begin
            if (final_byte)
            begin
                differ_next = '0;
                valid_next  = '0;
            end
            else
            begin
                differ_next = differ_upd;
                valid_next  = valid_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            differ_reg <= '0;
            valid_reg  <= '0;
        end
        else
        begin
            differ_reg <= differ_next;
            valid_reg  <= valid_next;
        end
    end

endmodule

### rtl/mihd_queue.sv
// ----------------------------------------------------------------------------
// Masked iris code Hamming distance: totals queue
// Short first-word-fall-through queue between the accumulator and the divider.
// ----------------------------------------------------------------------------
module mihd_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  mihd_pkg::mihd_totals_t wr_data,
    output logic                   full,
    input  logic                   rd_en,
    output mihd_pkg::mihd_totals_t rd_data,
    output logic                   empty
);
    import mihd_pkg::*;

    mihd_totals_t      entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_wr;
    logic              do_rd;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb
    begin
        full    = count_reg == QCNT_W'(QUEUE_DEPTH);
        empty   = count_reg == '0;
        rd_data = entry_reg[rd_ptr_reg];
        do_wr   = wr_en && !full;
        do_rd   = rd_en && !empty;

        wr_ptr_next = do_wr ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_rd ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/mihd_back.sv
// ----------------------------------------------------------------------------
// Masked iris code Hamming distance: divider and result register
// Takes template totals from the queue, forms differ / valid as a Q1.16
// fraction by restoring division, one quotient bit a cycle, and holds the
// result until it is popped.
// ----------------------------------------------------------------------------
module mihd_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  mihd_pkg::mihd_totals_t       q_data,
    output logic                         q_pop,
    input  logic                         pop,
    output logic                         empty,
    output logic [mihd_pkg::COUNT_W-1:0] differing_bits,
    output logic [mihd_pkg::COUNT_W-1:0] valid_bits,
    output logic [mihd_pkg::RATIO_W-1:0] distance_ratio,
    output logic                         no_valid_bits
);
    import mihd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [RATIO_W-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [COUNT_W-1:0] differ_reg, differ_next;
    logic [COUNT_W-1:0] valid_reg, valid_next;
    logic [RATIO_W-1:0] ratio_reg, ratio_next;
    logic               none_reg, none_next;
    logic [COUNT_W:0]   trial;
    logic               ge;

    always_comb
    begin
        // The first step compares the count itself; the ratio can be exactly one.
        trial = (step_reg == STEP_W'(DIV_STEPS)) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        ge    = trial >= {1'b0, valid_reg};

        state_next  = state_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        differ_next = differ_reg;
        valid_next  = valid_reg;
        ratio_next  = ratio_reg;
        none_next   = none_reg;
        q_pop       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    differ_next = q_data.differ;
                    valid_next  = q_data.valid;
                    rem_next    = q_data.differ;
                    quo_next    = '0;
                    step_next   = STEP_W'(DIV_STEPS);
                    if (q_data.valid == '0)
                    begin
                        none_next  = 1'b1;
                        ratio_next = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        none_next  = 1'b0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next  = ge ? COUNT_W'(trial - {1'b0, valid_reg}) : trial[COUNT_W-1:0];
                quo_next  = {quo_reg[RATIO_W-2:0], ge};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    ratio_next = {quo_reg[RATIO_W-2:0], ge};
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (pop)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        differ_reg <= differ_next;
        valid_reg  <= valid_next;
        ratio_reg  <= ratio_next;
        none_reg   <= none_next;
    end

    assign empty          = state_reg != ST_OUT;
    assign differing_bits = differ_reg;
    assign valid_bits     = valid_reg;
    assign distance_ratio = ratio_reg;
    assign no_valid_bits  = none_reg;

endmodule

### rtl/masked_iris_code_hamming_distance_unit.sv
// ----------------------------------------------------------------------------
// Masked iris code Hamming distance unit
// Fractional Hamming distance between two masked binary iris templates.
// ----------------------------------------------------------------------------
// The unit takes one byte pair of both templates per clock cycle for as long
// as full stays low; the accumulator stalls on every byte pair while full is
// high. A transfer marked final_byte closes the template: its totals go into a
// two-entry queue and the divider works them off, loading them, running 17
// restoring-division steps for the Q1.16 ratio and then presenting the result
// until pop takes it; when no bit was valid it skips the division steps. Full
// rises only when two finished templates are waiting, so the divider and the
// reader of results set how fast short templates can stream in.
// ----------------------------------------------------------------------------
module masked_iris_code_hamming_distance_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [mihd_pkg::BYTE_W-1:0]  code_a,
    input  logic [mihd_pkg::BYTE_W-1:0]  mask_a,
    input  logic [mihd_pkg::BYTE_W-1:0]  code_b,
    input  logic [mihd_pkg::BYTE_W-1:0]  mask_b,
    input  logic                         final_byte,
    output logic                         empty,
    input  logic                         pop,
    output logic [mihd_pkg::COUNT_W-1:0] differing_bits,
    output logic [mihd_pkg::COUNT_W-1:0] valid_bits,
    output logic [mihd_pkg::RATIO_W-1:0] distance_ratio,
    output logic                         no_valid_bits
);
    import mihd_pkg::*;

    mihd_totals_t push_data;
    mihd_totals_t pop_data;
    logic         q_push;
    logic         q_pop;
    logic         q_full;
    logic         q_empty;

    mihd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .code_a     (code_a),
        .mask_a     (mask_a),
        .code_b     (code_b),
        .mask_b     (mask_b),
        .final_byte (final_byte),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (push_data)
    );

    mihd_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (push_data),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (pop_data),
        .empty   (q_empty)
    );

    mihd_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_data         (pop_data),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .differing_bits (differing_bits),
        .valid_bits     (valid_bits),
        .distance_ratio (distance_ratio),
        .no_valid_bits  (no_valid_bits)
    );

    assign full = q_full;

endmodule

### rtl/mihd_checker.sv
// ----------------------------------------------------------------------------
// Masked iris code Hamming distance: port checker
// Watches the result side of the unit and checks what it shows over time.
// ----------------------------------------------------------------------------
module mihd_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         empty,
    input logic                         pop,
    input logic [mihd_pkg::COUNT_W-1:0] differing_bits,
    input logic [mihd_pkg::COUNT_W-1:0] valid_bits,
    input logic [mihd_pkg::RATIO_W-1:0] distance_ratio,
    input logic                         no_valid_bits
);
    import mihd_pkg::*;

    // An empty template reports zero counts and a zero ratio.
    a_empty_template: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && no_valid_bits) |-> (valid_bits == '0 && differing_bits == '0
                                       && distance_ratio == '0))
        else $error("no_valid_bits result with non-zero counts or ratio");

    // Differing bits are a subset of the jointly valid ones.
    a_differ_le_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (differing_bits <= valid_bits))
        else $error("differing_bits exceeds valid_bits");

    // The ratio never passes one, and it is one exactly when every valid bit differs.
    a_ratio_one: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !no_valid_bits) |->
            ((distance_ratio == RATIO_W'(1 << FRAC_BITS)) == (differing_bits == valid_bits)
             && distance_ratio <= RATIO_W'(1 << FRAC_BITS)))
        else $error("distance_ratio inconsistent with the counts");

    // A result that is not taken stays as it is.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(differing_bits) && $stable(valid_bits)
                              && $stable(distance_ratio) && $stable(no_valid_bits)))
        else $error("result changed while stalled");

endmodule

bind masked_iris_code_hamming_distance_unit mihd_checker u_mihd_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop            (pop),
    .differing_bits (differing_bits),
    .valid_bits     (valid_bits),
    .distance_ratio (distance_ratio),
    .no_valid_bits  (no_valid_bits)
);

### tb/tb_masked_iris_code_hamming_distance_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench: masked iris code Hamming distance unit
// A table of hand-picked byte pairs comes first, then one over-length
// template, then randomly sized templates in three idling regimes. Every
// transfer in is run through a local model of the distance calculation and
// every transfer out is compared with the oldest outstanding distance.
// ----------------------------------------------------------------------------
module tb_masked_iris_code_hamming_distance_unit;

    import mihd_pkg::*;

    localparam int NUM_ROWS       = 19;
    localparam int RANDOM_PAIRS   = 860;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 40;

    typedef struct packed {
        logic [BYTE_W-1:0] code_a;
        logic [BYTE_W-1:0] mask_a;
        logic [BYTE_W-1:0] code_b;
        logic [BYTE_W-1:0] mask_b;
        logic              final_byte;
    } byte_pair_t;

    typedef struct packed {
        logic [COUNT_W-1:0] differ;
        logic [COUNT_W-1:0] valid;
        logic [RATIO_W-1:0] ratio;
        logic               no_valid;
    } distance_t;

    typedef struct packed {
        byte_pair_t pair;
        logic       typed;
        distance_t  want;
    } directed_row_t;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [BYTE_W-1:0]   code_a;
    logic [BYTE_W-1:0]   mask_a;
    logic [BYTE_W-1:0]   code_b;
    logic [BYTE_W-1:0]   mask_b;
    logic                final_byte;
    logic                empty;
    logic                pop;
    logic [COUNT_W-1:0]  differing_bits;
    logic [COUNT_W-1:0]  valid_bits;
    logic [RATIO_W-1:0]  distance_ratio;
    logic                no_valid_bits;

    // Running totals of the template currently streaming in.
    logic [COUNT_W-1:0]  acc_differ;
    logic [COUNT_W-1:0]  acc_valid;

    distance_t           pending_distances [$];
    directed_row_t       directed_rows [NUM_ROWS];

    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  mismatches;
    int                  pairs_sent;
    int                  random_pairs;
    int                  templates_sent;
    int                  results_seen;
    int                  no_valid_seen;
    int                  dropped_pairs;
    int                  stall_cycles;

    masked_iris_code_hamming_distance_unit uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .code_a         (code_a),
        .mask_a         (mask_a),
        .code_b         (code_b),
        .mask_b         (mask_b),
        .final_byte     (final_byte),
        .empty          (empty),
        .pop            (pop),
        .differing_bits (differing_bits),
        .valid_bits     (valid_bits),
        .distance_ratio (distance_ratio),
        .no_valid_bits  (no_valid_bits)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Adds one byte pair to the running totals. A pair that would take the
    // valid count past the bit limit is dropped whole, but still closes the
    // template when it is marked final.
    function automatic bit accumulate_pair(input byte_pair_t p, output distance_t res);
        logic [BYTE_W-1:0]            joint;
        logic [BYTE_W-1:0]            diff;
        int                           nv;
        int                           nd;
        logic [COUNT_W+FRAC_BITS-1:0] num;
        logic [COUNT_W+FRAC_BITS-1:0] quo;
        joint = p.mask_a & p.mask_b;
        diff  = (p.code_a ^ p.code_b) & joint;
        nv    = $countones(joint);
        nd    = $countones(diff);
        res   = '0;
        if (int'(acc_valid) + nv <= BIT_LIMIT)
        begin
            acc_valid  = acc_valid + COUNT_W'(nv);
            acc_differ = acc_differ + COUNT_W'(nd);
        end
        else
        begin
            dropped_pairs++;
        end
        if (!p.final_byte)
        begin
            return 1'b0;
        end
        res.differ = acc_differ;
        res.valid  = acc_valid;
        if (acc_valid == '0)
        begin
            res.no_valid = 1'b1;
        end
        else
        begin
            num = {acc_differ, {FRAC_BITS{1'b0}}};
            quo = num / acc_valid;
            if (quo > (1 << FRAC_BITS))
            begin
                quo = 1 << FRAC_BITS;
            end
            res.ratio = quo[RATIO_W-1:0];
        end
        acc_differ = '0;
        acc_valid  = '0;
        return 1'b1;
    endfunction

    function automatic directed_row_t make_row(input logic [7:0] ca, input logic [7:0] ma,
                                               input logic [7:0] cb, input logic [7:0] mb,
                                               input logic fin, input logic typed,
                                               input int d, input int v, input int r,
                                               input logic nv);
        directed_row_t row_out;
        row_out.pair          = '{ca, ma, cb, mb, fin};
        row_out.typed         = typed;
        row_out.want.differ   = COUNT_W'(d);
        row_out.want.valid    = COUNT_W'(v);
        row_out.want.ratio    = RATIO_W'(r);
        row_out.want.no_valid = nv;
        return row_out;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_mask();
        case ($urandom_range(9))
            0, 1:    return 8'hFF;
            2:       return 8'h00;
            3:       return BYTE_W'($urandom_range(255) & $urandom_range(255));
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    // Offers one byte pair, with a random hold-off first, and waits for the
    // transfer. A typed distance replaces the modelled one on a final pair.
    task automatic push_pair(input byte_pair_t p, input logic typed, input distance_t want);
        distance_t res;
        bit        produced;
        if ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle_pct);
        end
        push       <= 1'b1;
        code_a     <= p.code_a;
        mask_a     <= p.mask_a;
        code_b     <= p.code_b;
        mask_b     <= p.mask_b;
        final_byte <= p.final_byte;
        do
        begin
            @(posedge clk);
        end
        while (full);
        produced = accumulate_pair(p, res);
        if (produced)
        begin
            pending_distances.push_back(typed ? want : res);
            templates_sent++;
        end
        pairs_sent++;
    endtask

    task automatic wait_for_drain();
        push <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_distances.size() != 0);
    endtask

    task automatic send_random_template(input int len);
        byte_pair_t p;
        int         flavour;
        for (int i = 0; i < len; i++)
        begin
            flavour      = $urandom_range(9);
            p.code_a     = BYTE_W'($urandom_range(255));
            p.code_b     = BYTE_W'($urandom_range(255));
            // Equal or inverted codes pull the ratio towards its extremes.
            if (flavour == 0)
            begin
                p.code_b = p.code_a;
            end
            else if (flavour == 1)
            begin
                p.code_b = ~p.code_a;
            end
            p.mask_a     = pick_mask();
            p.mask_b     = pick_mask();
            p.final_byte = (i == len - 1);
            push_pair(p, 1'b0, '0);
            random_pairs++;
        end
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        distance_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_distances.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got %0d/%0d",
                             $time, differing_bits, valid_bits);
                end
                else
                begin
                    want = pending_distances.pop_front();
                    compare_field("differing_bits", want.differ, differing_bits);
                    compare_field("valid_bits", want.valid, valid_bits);
                    compare_field("distance_ratio", want.ratio, distance_ratio);
                    compare_field("no_valid_bits", want.no_valid, no_valid_bits);
                    results_seen++;
                    if (want.no_valid)
                    begin
                        no_valid_seen++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
                $display("end of test: mismatches");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial
    begin
        byte_pair_t p;
        distance_t  want;
        rst_n          = 1'b0;
        push           = 1'b0;
        pop            = 1'b0;
        code_a         = '0;
        mask_a         = '0;
        code_b         = '0;
        mask_b         = '0;
        final_byte     = 1'b0;
        acc_differ     = '0;
        acc_valid      = '0;
        mismatches     = 0;
        pairs_sent     = 0;
        random_pairs   = 0;
        templates_sent = 0;
        results_seen   = 0;
        no_valid_seen  = 0;
        dropped_pairs  = 0;
        stall_cycles   = 0;
        send_idle_pct  = 16;
        recv_idle_pct  = 55;

        // Nothing valid straight after reset, single-byte extremes, masks
        // that cancel each other, then a few short multi-byte templates.
        directed_rows[0]  = make_row(8'h00, 8'h00, 8'h00, 8'h00, 1, 1, 0, 0, 0, 1);
        directed_rows[1]  = make_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 1, 0, 8, 0, 0);
        directed_rows[2]  = make_row(8'hFF, 8'hFF, 8'h00, 8'hFF, 1, 1, 8, 8, 65536, 0);
        directed_rows[3]  = make_row(8'h00, 8'hFF, 8'hFF, 8'hFF, 1, 1, 8, 8, 65536, 0);
        directed_rows[4]  = make_row(8'hAA, 8'hFF, 8'h55, 8'h00, 1, 1, 0, 0, 0, 1);
        directed_rows[5]  = make_row(8'hAA, 8'h00, 8'h55, 8'hFF, 1, 1, 0, 0, 0, 1);
        directed_rows[6]  = make_row(8'hC3, 8'h3C, 8'h3C, 8'hC3, 1, 1, 0, 0, 0, 1);
        directed_rows[7]  = make_row(8'hF0, 8'hFF, 8'h00, 8'hFF, 1, 1, 4, 8, 32768, 0);
        directed_rows[8]  = make_row(8'h0F, 8'hFF, 8'h00, 8'hFF, 0, 0, 0, 0, 0, 0);
        directed_rows[9]  = make_row(8'h00, 8'hFF, 8'h00, 8'hFF, 1, 1, 4, 16, 16384, 0);
        directed_rows[10] = make_row(8'h01, 8'h01, 8'h00, 8'h01, 0, 0, 0, 0, 0, 0);
        directed_rows[11] = make_row(8'h00, 8'h01, 8'h00, 8'h01, 0, 0, 0, 0, 0, 0);
        directed_rows[12] = make_row(8'h00, 8'h01, 8'h00, 8'h01, 1, 0, 0, 0, 0, 0);
        directed_rows[13] = make_row(8'h80, 8'h80, 8'h00, 8'h80, 0, 0, 0, 0, 0, 0);
        directed_rows[14] = make_row(8'hFF, 8'h00, 8'h00, 8'h00, 1, 1, 1, 1, 65536, 0);
        directed_rows[15] = make_row(8'h5A, 8'hE7, 8'hA5, 8'h7E, 0, 0, 0, 0, 0, 0);
        directed_rows[16] = make_row(8'h3C, 8'hFF, 8'hC3, 8'h0F, 1, 0, 0, 0, 0, 0);
        directed_rows[17] = make_row(8'h01, 8'hFF, 8'h00, 8'h01, 1, 1, 1, 1, 65536, 0);
        directed_rows[18] = make_row(8'hFE, 8'h7F, 8'h01, 8'hFF, 1, 0, 0, 0, 0, 0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            push_pair(directed_rows[i].pair, directed_rows[i].typed, directed_rows[i].want);
        end
        wait_for_drain();

        // Over-length template: every valid bit differs until both counts sit
        // at the bit limit, and the closing pair with a single differing valid
        // bit no longer fits, so it is dropped whole.
        want = '{COUNT_W'(BIT_LIMIT), COUNT_W'(BIT_LIMIT), RATIO_W'(65536), 1'b0};
        for (int i = 0; i <= MAX_BYTES; i++)
        begin
            p = '{8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b0};
            if (i == MAX_BYTES)
            begin
                p = '{8'h01, 8'h01, 8'h00, 8'h01, 1'b1};
            end
            push_pair(p, i == MAX_BYTES, want);
        end
        wait_for_drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 16;
                    recv_idle_pct = 55;
                end
                1:
                begin
                    send_idle_pct = 55;
                    recv_idle_pct = 16;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            while (random_pairs < (phase + 1) * RANDOM_PAIRS / 3)
            begin
                send_random_template(($urandom_range(3) == 0) ? 1 : $urandom_range(2, 30));
            end
            wait_for_drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d byte pairs in %0d templates (%0d random), %0d dropped at the limit.",
                 pairs_sent, templates_sent, random_pairs, dropped_pairs);
        $display("Checked %0d distances, %0d of them with no jointly valid bit.",
                 results_seen, no_valid_seen);
        if (mismatches == 0 && pending_distances.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
